// File: sv/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Defining NO_ASSERTIONS removes every assertion from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Types, constants and helpers for the epoch reclamation manager.
// ----------------------------------------------------------------------------
`default_nettype none

package erm_pkg;

	localparam int THREADS = 8;
	localparam int EPOCHS  = 3;

	localparam int OPCODE_W = 2;
	localparam int THREAD_W = 3;
	localparam int EPOCH_W  = 2;
	localparam int COUNT_W  = 16;
	localparam int TID_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int SLOTS    = THREADS * EPOCHS;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [THREAD_W-1:0] thread_t;
	typedef logic [TID_W-1:0]    tid_t;
	typedef logic [EPOCH_W-1:0]  epoch_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [SLOT_W-1:0]   slot_t;

	localparam opcode_t OP_ENTER  = 2'd0;
	localparam opcode_t OP_EXIT   = 2'd1;
	localparam opcode_t OP_RETIRE = 2'd2;

	localparam count_t COUNT_MAX       = '1;
	localparam count_t THRESHOLD_RESET = COUNT_W'(100);
	localparam epoch_t GLOBAL_RESET    = EPOCH_W'(1 % EPOCHS);
	localparam epoch_t EPOCH_LAST      = EPOCH_W'(EPOCHS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP0,
		S_STEP1,
		S_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic first_pass;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic step_done;
		logic out_busy;
	} dp_status_t;

	function automatic slot_t slot_index(input tid_t t, input epoch_t e);
		return slot_t'(int'(t) * EPOCHS + int'(e));
	endfunction

endpackage

`default_nettype wire

// File: sv/erm_ctrl.sv
// ----------------------------------------------------------------------------
// erm_ctrl
// Sequencer: takes an operation, runs one pass (two when an enter hits its
// threshold), hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module erm_ctrl
	import erm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_STEP0;
			end
			S_STEP0: begin
				state_d = status.step_done ? S_EMIT : S_STEP1;
			end
			S_STEP1: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!status.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			S_STEP0: begin
				cmd.step = 1'b1;
				cmd.first_pass = 1'b1;
			end
			S_STEP1: begin
				cmd.step = 1'b1;
			end
			S_EMIT: begin
				cmd.emit = !status.out_busy;
			end
			default: ;
		endcase
	end

	`ASSERT_RST(a_capture_steps, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_STEP0), "accepted beat did not start a pass")
	`ASSERT_RST(a_emit_free, clk, arst_n, cmd.emit |-> !status.out_busy, "result emitted over a waiting beat")
	`ASSERT_RST(a_second_pass, clk, arst_n, (state_q == S_STEP1) |-> $past(state_q == S_STEP0 && !status.step_done), "second pass without a failed first pass")

endmodule

`default_nettype wire

// File: sv/erm_datapath.sv
// ----------------------------------------------------------------------------
// erm_datapath
// Per-thread state, pending counts, global epoch, threshold register and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module erm_datapath
	import erm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_wr_en,
	input  wire count_t    cfg_wr_data,
	input  wire opcode_t   opcode,
	input  wire thread_t   thread,
	input  wire ctrl_cmd_t cmd,
	output dp_status_t     status,
	output logic           out_valid,
	input  wire logic      out_ready,
	output epoch_t         epoch,
	output logic           reclaimed,
	output epoch_t         reclaim_epoch,
	output count_t         reclaim_count,
	output logic           advanced
);

	count_t  threshold_q;
	epoch_t  global_q;
	logic    crit_q   [THREADS];
	epoch_t  local_q  [THREADS];
	count_t  entries_q[THREADS];
	count_t  pending_q[SLOTS];

	opcode_t op_q;
	thread_t thread_q;
	logic    rec_q;
	epoch_t  rec_epoch_q;
	count_t  rec_count_q;
	logic    adv_q;

	logic    out_valid_q;
	epoch_t  out_epoch_q;
	logic    out_rec_q;
	epoch_t  out_rec_epoch_q;
	count_t  out_rec_count_q;
	logic    out_adv_q;

	tid_t    tid;
	logic    thread_ok;
	logic    lag;
	logic    blocked;
	count_t  cur_count;
	slot_t   slot;
	count_t  pend_rd;
	epoch_t  global_next;

	logic    flag_wr, flag_val;
	logic    local_wr;
	logic    count_wr;
	count_t  count_val;
	logic    pend_wr;
	count_t  pend_val;
	logic    global_wr;
	logic    rec_set;
	logic    step_done;

	assign tid       = tid_t'(thread_q);
	assign thread_ok = int'(thread_q) < THREADS;
	assign lag       = local_q[tid] != global_q;
	assign cur_count = entries_q[tid];
	assign slot      = slot_index(tid, (op_q == OP_RETIRE) ? local_q[tid] : global_q);
	assign pend_rd   = pending_q[slot];
	assign global_next = (global_q == EPOCH_LAST) ? '0 : global_q + EPOCH_W'(1);

	// The entering thread's own flag is left out of this check.
	always_comb begin
		blocked = 1'b0;
		for (int i = 0; i < THREADS; i++) begin
			if (tid_t'(i) != tid && crit_q[i] && local_q[i] != global_q) blocked = 1'b1;
		end
	end

	always_comb begin
		flag_wr   = 1'b0;
		flag_val  = 1'b0;
		local_wr  = 1'b0;
		count_wr  = 1'b0;
		count_val = '0;
		pend_wr   = 1'b0;
		pend_val  = '0;
		global_wr = 1'b0;
		rec_set   = 1'b0;
		step_done = 1'b1;
		if (cmd.step && thread_ok) begin
			case (op_q)
				OP_ENTER: begin
					flag_wr  = 1'b1;
					flag_val = 1'b1;
					if (lag) begin
						rec_set  = 1'b1;
						pend_wr  = 1'b1;
						local_wr = 1'b1;
						count_wr = 1'b1;
					end else if (cur_count < threshold_q) begin
						count_wr  = 1'b1;
						count_val = cur_count + COUNT_W'(1);
					end else begin
						flag_val  = 1'b0;
						count_wr  = 1'b1;
						global_wr = !blocked;
						step_done = !cmd.first_pass;
					end
				end
				OP_EXIT: begin
					flag_wr = 1'b1;
				end
				OP_RETIRE: begin
					if (pend_rd != COUNT_MAX) begin
						pend_wr  = 1'b1;
						pend_val = pend_rd + COUNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			global_q    <= GLOBAL_RESET;
			for (int i = 0; i < THREADS; i++) begin
				crit_q[i]    <= 1'b0;
				local_q[i]   <= '0;
				entries_q[i] <= '0;
			end
			for (int i = 0; i < SLOTS; i++) begin
				pending_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				threshold_q <= (cfg_wr_data == '0) ? COUNT_W'(1) : cfg_wr_data;
			end
			if (global_wr) global_q <= global_next;
			if (flag_wr) crit_q[tid] <= flag_val;
			if (local_wr) local_q[tid] <= global_q;
			if (count_wr) entries_q[tid] <= count_val;
			if (pend_wr) pending_q[slot] <= pend_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			thread_q <= thread;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q       <= 1'b0;
			rec_epoch_q <= '0;
			rec_count_q <= '0;
			adv_q       <= 1'b0;
		end else if (cmd.capture) begin
			rec_q       <= 1'b0;
			rec_epoch_q <= '0;
			rec_count_q <= '0;
			adv_q       <= 1'b0;
		end else begin
			if (rec_set) begin
				rec_q       <= 1'b1;
				rec_epoch_q <= global_q;
				rec_count_q <= pend_rd;
			end
			if (global_wr) adv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_epoch_q     <= thread_ok ? local_q[tid] : '0;
			out_rec_q       <= rec_q;
			out_rec_epoch_q <= rec_epoch_q;
			out_rec_count_q <= rec_count_q;
			out_adv_q       <= adv_q;
		end
	end

	assign status.step_done = step_done;
	assign status.out_busy  = out_valid_q && !out_ready;

	assign out_valid     = out_valid_q;
	assign epoch         = out_epoch_q;
	assign reclaimed     = out_rec_q;
	assign reclaim_epoch = out_rec_epoch_q;
	assign reclaim_count = out_rec_count_q;
	assign advanced      = out_adv_q;

	`ASSERT_RST(a_global_range, clk, arst_n, int'(global_q) < EPOCHS, "global epoch out of range")
	`ASSERT_RST(a_threshold_nonzero, clk, arst_n, threshold_q != '0, "zero entry threshold")
	`ASSERT_RST(a_second_pass_ends, clk, arst_n, (cmd.step && !cmd.first_pass) |-> step_done, "second enter pass did not finish")

endmodule

`default_nettype wire

// File: sv/epoch_reclamation_manager.sv
// ----------------------------------------------------------------------------
// epoch_reclamation_manager
// Epoch-based reclamation bookkeeping for a fixed set of threads.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one operation per beat: opcode
// (enter, exit, retire) and the issuing thread. The output channel
// (out_valid/out_ready) returns one result beat per operation, in order:
// the thread's local epoch and, for enter, any released pending count and
// whether the global epoch advanced.
// After an input beat is accepted the state machine walks capture, one pass
// (two when an enter hits its threshold and repeats its check) and an output
// load that registers out_valid; a new beat is taken only after that load.
// A finished result sits in the output register; the next beat is accepted
// and worked on while it waits, and only the output load stalls until the
// receiver takes the previous beat.
// The entry threshold is written through cfg_wr_en/cfg_wr_data while the
// block is idle; the user must keep to this, as the block does not enforce
// it. A zero write is held as one.
// Reset: threshold 100, global epoch 1, all flags, local epochs, entry
// counters and pending counts zero, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_reclamation_manager
	import erm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_wr_en,
	input  wire count_t  cfg_wr_data,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire opcode_t opcode,
	input  wire thread_t thread,
	output logic         out_valid,
	input  wire logic    out_ready,
	output epoch_t       epoch,
	output logic         reclaimed,
	output epoch_t       reclaim_epoch,
	output count_t       reclaim_count,
	output logic         advanced
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	erm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	erm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.opcode        (opcode),
		.thread        (thread),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.epoch         (epoch),
		.reclaimed     (reclaimed),
		.reclaim_epoch (reclaim_epoch),
		.reclaim_count (reclaim_count),
		.advanced      (advanced)
	);

endmodule

`default_nettype wire
